// File: sv/secs_pkg.sv
package secs_pkg;

    // fixed block size of the cycle counter
    localparam int CYCLES_PER_BLOCK = 1000;
    localparam int SUB_W = $clog2(CYCLES_PER_BLOCK + 1);

    // configuration register indexes
    localparam logic [1:0] CFG_GOAL_POSITION = 2'd0;
    localparam logic [1:0] CFG_STEP_SIZE     = 2'd1;
    localparam logic [1:0] CFG_START_BLOCK   = 2'd2;

    // configuration reset values
    localparam logic signed [31:0] GOAL_RESET  = 32'sd6000000;
    localparam logic [23:0]        STEP_RESET  = 24'd25000;
    localparam logic [15:0]        START_RESET = 16'd10;

    // status masks and control words
    localparam logic [15:0] SW_RUNG1_MASK  = 16'h0031;
    localparam logic [15:0] SW_RUNG2_MASK  = 16'h0033;
    localparam logic [15:0] SW_RUNG3_MASK  = 16'h0433;
    localparam logic [15:0] SW_READY_MASK  = 16'h0250;
    localparam logic [15:0] SW_NOT_DONE    = 16'd1075 + 16'h1204;
    localparam logic [15:0] SW_CSP_READY   = 16'h0233;
    localparam logic [15:0] CW_FAULT_RESET = 16'h0080;
    localparam logic [15:0] CW_SHUTDOWN    = 16'h0006;
    localparam logic [15:0] CW_SWITCH_ON   = 16'h0007;
    localparam logic [15:0] CW_ENABLE      = 16'h000f;
    localparam logic [15:0] CW_START       = 16'h001f;
    localparam logic [15:0] CW_NONE        = 16'h0000;

    localparam logic [3:0]  LINK_OP     = 4'd8;
    localparam logic [7:0]  MODE_HOMING = 8'd6;
    localparam logic [7:0]  MODE_CSP    = 8'd8;

    typedef enum logic [1:0] {
        PH_SAFE   = 2'd0,
        PH_ENABLE = 2'd1,
        PH_RUN    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        MS_WAIT = 2'd0,
        MS_MOVE = 2'd1,
        MS_DONE = 2'd2
    } t_motion;

    typedef struct packed {
        logic               master_operational;
        logic [3:0]         drive_link_state;
        logic [15:0]        status_word;
        logic [15:0]        error_code;
        logic signed [31:0] actual_position;
        logic [7:0]         mode_display;
    } t_in;

    typedef struct packed {
        logic [15:0]        control_word;
        logic [7:0]         operation_mode;
        logic signed [31:0] commanded_position;
        logic               position_updated;
        logic [1:0]         phase;
        logic               homed;
        logic               csp_ready;
        logic [1:0]         motion_status;
    } t_out;

endpackage

// File: sv/servo_enable_home_csp_sequencer.sv
// a result beat appears in the cycle after its input beat is accepted
// throughput: one beat per cycle while not stalled; the whole step is one pass
//   of logic from the accepted beat and sequencer state into the result register
// reset (synchronous, active low): sequencer state, cycle counter and output valid
//   clear, configuration registers return to their defaults
module servo_enable_home_csp_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  secs_pkg::t_in       i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output secs_pkg::t_out      o_out,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);

    // ladder of control words from the status word
    function automatic logic [15:0] ladder(input logic [15:0] s);
        logic [15:0] l;
        if ((s & secs_pkg::SW_RUNG1_MASK) != secs_pkg::SW_RUNG1_MASK) begin
            l = secs_pkg::CW_NONE;
        end else if ((s & secs_pkg::SW_RUNG2_MASK) != secs_pkg::SW_RUNG2_MASK) begin
            l = secs_pkg::CW_SWITCH_ON;
        end else if ((s & secs_pkg::SW_RUNG3_MASK) != secs_pkg::SW_RUNG3_MASK) begin
            l = secs_pkg::CW_ENABLE;
        end else begin
            l = secs_pkg::CW_START;
        end
        return l;
    endfunction

    // configuration
    logic signed [31:0] r_goal;
    logic [23:0]        r_step;
    logic [15:0]        r_start;

    // sequencer state
    secs_pkg::t_phase          r_phase, n_phase;
    logic [31:0]               r_cyc, n_cyc;
    logic [secs_pkg::SUB_W-1:0] r_sub, n_sub;
    logic [31:0]               r_blk, n_blk;
    logic                      r_mode_sent, n_mode_sent;
    logic                      r_homed, n_homed;
    logic                      r_switched, n_switched;
    logic                      r_csp, n_csp;
    logic                      r_men, n_men;
    secs_pkg::t_motion         r_ms, n_ms;
    logic [15:0]               r_cw, n_cw;
    logic [7:0]                r_mode, n_mode;
    logic signed [31:0]        r_pos, n_pos;
    logic                      n_updated;

    // output register
    secs_pkg::t_out r_out, n_out;
    logic           r_out_valid;
    logic           w_accept;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // status decode
    logic [15:0] w_ladder;
    logic        w_fault;
    assign w_ladder = ladder(i_in.status_word);
    assign w_fault  = (i_in.error_code != 16'd0) || i_in.status_word[3];

    // move step arithmetic at full width, no wrap
    logic signed [33:0] w_g, w_c, w_ag, w_ac, w_d, w_ad, w_sp, w_up, w_dn;
    logic               w_far, w_at_goal, w_below, w_pass_up, w_pass_dn;
    assign w_g       = {{2{r_goal[31]}}, r_goal};
    assign w_c       = {{2{i_in.actual_position[31]}}, i_in.actual_position};
    assign w_sp      = {10'd0, r_step};
    assign w_ag      = w_g[33] ? -w_g : w_g;
    assign w_ac      = w_c[33] ? -w_c : w_c;
    assign w_d       = w_ag - w_ac;
    assign w_ad      = w_d[33] ? -w_d : w_d;
    assign w_far     = w_ad > w_sp;
    assign w_at_goal = w_c == w_g;
    assign w_below   = w_c < w_g;
    assign w_up      = w_c + w_sp;
    assign w_dn      = w_c - w_sp;
    assign w_pass_up = w_up > w_g;
    assign w_pass_dn = w_dn < w_g;

    // block index after this cycle's count
    logic w_in_block;

    always_comb begin
        if (r_cyc == 32'hffff_ffff) begin
            n_cyc = 32'd0;
            n_sub = '0;
            n_blk = 32'd0;
        end else if (r_sub == secs_pkg::SUB_W'(secs_pkg::CYCLES_PER_BLOCK - 1)) begin
            n_cyc = r_cyc + 32'd1;
            n_sub = '0;
            n_blk = r_blk + 32'd1;
        end else begin
            n_cyc = r_cyc + 32'd1;
            n_sub = r_sub + secs_pkg::SUB_W'(1);
            n_blk = r_blk;
        end
        w_in_block = n_blk == {16'd0, r_start};
    end

    // one sequencer step
    always_comb begin
        n_phase     = r_phase;
        n_mode_sent = r_mode_sent;
        n_homed     = r_homed;
        n_switched  = r_switched;
        n_csp       = r_csp;
        n_men       = r_men;
        n_ms        = r_ms;
        n_cw        = r_cw;
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_updated   = 1'b0;
        case (r_phase)
            secs_pkg::PH_SAFE: begin
                if (i_in.master_operational && i_in.drive_link_state == secs_pkg::LINK_OP) begin
                    n_phase = secs_pkg::PH_ENABLE;
                end
            end
            secs_pkg::PH_ENABLE: begin
                if (!r_mode_sent) begin
                    n_mode      = secs_pkg::MODE_HOMING;
                    n_mode_sent = 1'b1;
                end
                n_cw = secs_pkg::CW_FAULT_RESET;
                if ((i_in.status_word & secs_pkg::SW_READY_MASK) == secs_pkg::SW_READY_MASK) begin
                    n_cw = secs_pkg::CW_SHUTDOWN;
                end
                if (w_fault) begin
                    n_cw = n_cw | secs_pkg::CW_FAULT_RESET;
                end
                if (w_ladder != secs_pkg::CW_NONE) begin
                    n_cw = w_ladder;
                end
                if (w_ladder == secs_pkg::CW_START && i_in.status_word != secs_pkg::SW_NOT_DONE
                        && i_in.status_word[2]) begin
                    n_phase = secs_pkg::PH_RUN;
                end
            end
            default: begin
                // fault capture
                if (w_fault) begin
                    n_cw = r_cw | secs_pkg::CW_FAULT_RESET;
                    if (w_ladder != secs_pkg::CW_NONE) begin
                        n_cw = w_ladder;
                    end
                end
                if (i_in.status_word[12]) begin
                    n_homed = 1'b1;
                end
                // switch to cyclic position mode
                if (n_homed && !r_csp) begin
                    if (r_switched) begin
                        n_csp = 1'b1;
                    end else begin
                        n_cw = secs_pkg::CW_SWITCH_ON;
                        if (i_in.status_word == secs_pkg::SW_CSP_READY) begin
                            n_mode = secs_pkg::MODE_CSP;
                            if (i_in.mode_display == secs_pkg::MODE_CSP) begin
                                n_switched = 1'b1;
                                n_cw       = secs_pkg::CW_ENABLE;
                                n_ms       = secs_pkg::MS_WAIT;
                            end
                        end
                    end
                end
                // motion step toward the goal
                if (n_csp) begin
                    if (w_in_block) begin
                        n_men = 1'b1;
                    end
                    if (n_men) begin
                        if (w_far) begin
                            n_ms = secs_pkg::MS_MOVE;
                        end
                        if (!w_at_goal) begin
                            n_updated = 1'b1;
                            if (w_below) begin
                                n_pos = w_up[31:0];
                                if (w_pass_up) begin
                                    n_ms  = secs_pkg::MS_DONE;
                                    n_men = 1'b0;
                                    n_pos = r_goal;
                                    n_cw  = secs_pkg::CW_SWITCH_ON;
                                end
                            end else begin
                                n_pos = w_dn[31:0];
                                if (w_pass_dn) begin
                                    n_ms  = secs_pkg::MS_DONE;
                                    n_men = 1'b0;
                                    n_pos = r_goal;
                                    n_cw  = secs_pkg::CW_SWITCH_ON;
                                end
                            end
                        end
                    end
                end
            end
        endcase
    end

    // result beat
    always_comb begin
        n_out.control_word       = n_cw;
        n_out.operation_mode     = n_mode;
        n_out.commanded_position = n_pos;
        n_out.position_updated   = n_updated;
        n_out.phase              = n_phase;
        n_out.homed              = n_homed;
        n_out.csp_ready          = n_csp;
        n_out.motion_status      = n_ms;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal  <= secs_pkg::GOAL_RESET;
            r_step  <= secs_pkg::STEP_RESET;
            r_start <= secs_pkg::START_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                secs_pkg::CFG_GOAL_POSITION: r_goal  <= i_cfg_data;
                secs_pkg::CFG_STEP_SIZE:     r_step  <= i_cfg_data[23:0];
                secs_pkg::CFG_START_BLOCK:   r_start <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= secs_pkg::PH_SAFE;
            r_cyc       <= 32'd0;
            r_sub       <= '0;
            r_blk       <= 32'd0;
            r_mode_sent <= 1'b0;
            r_homed     <= 1'b0;
            r_switched  <= 1'b0;
            r_csp       <= 1'b0;
            r_men       <= 1'b0;
            r_ms        <= secs_pkg::MS_WAIT;
            r_cw        <= 16'd0;
            r_mode      <= 8'd0;
            r_pos       <= 32'sd0;
        end else if (w_accept) begin
            r_phase     <= n_phase;
            r_cyc       <= n_cyc;
            r_sub       <= n_sub;
            r_blk       <= n_blk;
            r_mode_sent <= n_mode_sent;
            r_homed     <= n_homed;
            r_switched  <= n_switched;
            r_csp       <= n_csp;
            r_men       <= n_men;
            r_ms        <= n_ms;
            r_cw        <= n_cw;
            r_mode      <= n_mode;
            r_pos       <= n_pos;
        end
    end

    // output register and its valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

endmodule

// File: sv/secs_checker.sv
module secs_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input secs_pkg::t_out o_out
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result beat changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // an accepted input beat always yields a result beat next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted beat gave no result");

    // position writes only happen in run phase with csp mode active
    a_update_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.position_updated |->
            o_out.phase == secs_pkg::PH_RUN && o_out.csp_ready && o_out.homed)
        else $error("position written outside cyclic position run");

    // csp readiness needs homing seen
    a_csp_homed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.csp_ready |-> o_out.homed && o_out.phase != 2'd3)
        else $error("csp ready without homing");

endmodule

bind servo_enable_home_csp_sequencer secs_checker u_secs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
